>>> hw/rtl/lsar_pkg.sv
// Shared types, constants and code tables of the light sensor auto-range block.
package lsar_pkg;

    localparam int COUNT_W        = 20;  // raw count field width
    localparam int MODE_W         = 2;
    localparam int CODE_W         = 3;   // gain, integration and rate codes
    localparam int WAIT_W         = 11;
    localparam int COUNT_BITS_DEF = 20;

    localparam logic [CODE_W-1:0] GAIN_MAX  = 3'd4;
    localparam logic [CODE_W-1:0] INTEG_MAX = 3'd5;
    localparam logic [CODE_W-1:0] RATE_SAT  = 3'd6;

    // Shortest integration time uses a fixed 13-bit full scale
    localparam int FS_BITS_SHORT = 13;

    localparam logic [CODE_W-1:0] GAIN_RST  = 3'd1;
    localparam logic [CODE_W-1:0] INTEG_RST = 3'd2;
    localparam logic [CODE_W-1:0] RATE_RST  = 3'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_AMBIENT   = 2'd0,
        MODE_UV        = 2'd1,
        MODE_ALTERNATE = 2'd2,
        MODE_HOLD      = 2'd3
    } mode_t;

    typedef struct packed {
        logic [CODE_W-1:0] gain;
        logic [CODE_W-1:0] integ;
        logic [CODE_W-1:0] rate;
    } chan_set_t;

    typedef struct packed {
        chan_set_t set;
        logic      needed;
    } range_out_t;

    // Measurement period in ms for a rate code
    function automatic logic [WAIT_W-1:0] rate_period_ms(input logic [CODE_W-1:0] code);
        logic [WAIT_W-1:0] p;
        case (code)
            3'd0:    p = 11'd25;
            3'd1:    p = 11'd50;
            3'd2:    p = 11'd100;
            3'd3:    p = 11'd200;
            3'd4:    p = 11'd500;
            3'd5:    p = 11'd1000;
            default: p = 11'd2000;
        endcase
        return p;
    endfunction

    // Lowest rate code whose period covers the integration time of a code
    function automatic logic [CODE_W-1:0] min_rate_code(input logic [CODE_W-1:0] integ);
        logic [CODE_W-1:0] r;
        case (integ)
            3'd0:    r = 3'd4;   // 400 ms -> 500 ms
            3'd1:    r = 3'd3;   // 200 ms -> 200 ms
            3'd2:    r = 3'd2;   // 100 ms -> 100 ms
            3'd3:    r = 3'd1;   // 50 ms  -> 50 ms
            default: r = 3'd0;   // 25 ms and shorter
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/lsar_range.sv
// Auto-range step of one channel: thresholds, gain/integration steps, rate raise.
module lsar_range #(
    parameter int COUNT_BITS = lsar_pkg::COUNT_BITS_DEF
) (
    input  logic [lsar_pkg::COUNT_W-1:0] count,
    input  lsar_pkg::chan_set_t          cur,
    output lsar_pkg::range_out_t         res
);

    localparam int XW   = lsar_pkg::COUNT_W + 4;
    localparam int FW   = COUNT_BITS + 5;
    localparam int CW   = (XW > FW) ? XW : FW;
    localparam int SH_W = $clog2(COUNT_BITS + 1);

    logic [CW-1:0]   x;
    logic [CW-1:0]   fs;
    logic [SH_W-1:0] fs_shift;
    logic            below_lo;
    logic            below_dark;
    logic            above_hi;
    logic            above_sat;

    always_comb begin
        x = (CW'(count) << 3) + (CW'(count) << 1);
        if (cur.integ >= lsar_pkg::INTEG_MAX) begin
            fs_shift = SH_W'(lsar_pkg::FS_BITS_SHORT);
        end else begin
            fs_shift = SH_W'(COUNT_BITS) - SH_W'(cur.integ);
        end
        fs = CW'(1) << fs_shift;

        below_lo   = x < (fs << 1);
        below_dark = x < fs;
        above_hi   = x > (fs << 3);
        above_sat  = x > ((fs << 3) + fs);
    end

    always_comb begin
        res = '0;
        res.set = cur;
        res.needed = below_lo | below_dark | above_hi | above_sat;
        if (below_lo && cur.gain < lsar_pkg::GAIN_MAX) begin
            res.set.gain = cur.gain + 3'd1;
        end
        if (below_dark && cur.integ != '0) begin
            res.set.integ = cur.integ - 3'd1;
        end
        if (above_hi && cur.gain != '0) begin
            res.set.gain = cur.gain - 3'd1;
        end
        if (above_sat && cur.integ < lsar_pkg::INTEG_MAX) begin
            res.set.integ = cur.integ + 3'd1;
        end
        // Raise the rate until its period covers the integration time
        if (cur.rate < lsar_pkg::min_rate_code(res.set.integ)) begin
            res.set.rate = lsar_pkg::min_rate_code(res.set.integ);
        end
    end

endmodule

>>> hw/rtl/light_sensor_auto_range_top.sv
// Top level of the light sensor auto-range controller.
// Pipeline: an accepted input transaction is held in the input register, then
//   moves to the result register once the result slot is free.
// Throughput: one transaction per cycle while m_ready is high; the per-channel
//   state is updated in the same cycle a result is loaded, so the next item sees it.
// Reset (aresetn, synchronous, active low): both stages empty, mode alternate,
//   ambient channel first, all channels at gain code 1, 100 ms integ and rate.
module light_sensor_auto_range_top #(
    parameter int COUNT_BITS = lsar_pkg::COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [lsar_pkg::MODE_W-1:0]     cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lsar_pkg::COUNT_W-1:0]    s_raw_count,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_measured_is_uv,
    output logic [lsar_pkg::COUNT_W-1:0]    m_count_echo,
    output logic                            m_next_is_uv,
    output logic                            m_rescale_needed,
    output logic [lsar_pkg::CODE_W-1:0]     m_next_gain_code,
    output logic [lsar_pkg::CODE_W-1:0]     m_next_integration_code,
    output logic [lsar_pkg::CODE_W-1:0]     m_next_rate_code,
    output logic                            m_settings_changed,
    output logic [lsar_pkg::WAIT_W-1:0]     m_wait_ms
);

    // Configuration
    lsar_pkg::mode_t mode_reg;

    // Input register
    logic                         in_valid_reg;
    logic [lsar_pkg::COUNT_W-1:0] raw_reg;

    // Channel state
    logic                         current_is_uv_reg;
    logic [lsar_pkg::COUNT_W-1:0] count_reg [2];
    lsar_pkg::chan_set_t          chan_reg  [2];
    logic                         applied_is_uv_reg;
    lsar_pkg::chan_set_t          applied_reg;

    // Result register
    logic                         out_valid_reg;
    logic                         measured_reg;
    logic [lsar_pkg::COUNT_W-1:0] echo_reg;
    logic                         next_uv_reg;
    logic                         needed_reg;
    lsar_pkg::chan_set_t          set_reg;
    logic                         changed_reg;
    logic [lsar_pkg::WAIT_W-1:0]  wait_reg;

    logic                         advance;
    logic                         next_is_uv;
    logic [lsar_pkg::COUNT_W-1:0] next_count;
    lsar_pkg::range_out_t         range_res;
    logic                         changed;

    // Advance the input register into the result register whenever the
    // result slot is free or is being emptied this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Pick the next channel from the mode
    always_comb begin
        case (mode_reg)
            lsar_pkg::MODE_AMBIENT:   next_is_uv = 1'b0;
            lsar_pkg::MODE_UV:        next_is_uv = 1'b1;
            lsar_pkg::MODE_ALTERNATE: next_is_uv = !current_is_uv_reg;
            default:                  next_is_uv = current_is_uv_reg;
        endcase
    end

    // Forward the count just stored when the next channel is the one measured
    assign next_count = (next_is_uv == current_is_uv_reg) ? raw_reg : count_reg[next_is_uv];

    lsar_range #(
        .COUNT_BITS (COUNT_BITS)
    ) u_range (
        .count (next_count),
        .cur   (chan_reg[next_is_uv]),
        .res   (range_res)
    );

    assign changed = (next_is_uv != applied_is_uv_reg) || (range_res.set != applied_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= lsar_pkg::MODE_ALTERNATE;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            current_is_uv_reg <= 1'b0;
            applied_is_uv_reg <= 1'b0;
            applied_reg       <= '{gain: lsar_pkg::GAIN_RST, integ: lsar_pkg::INTEG_RST,
                                   rate: lsar_pkg::RATE_RST};
            for (int c = 0; c < 2; c++) begin
                count_reg[c] <= '0;
                chan_reg[c]  <= '{gain: lsar_pkg::GAIN_RST, integ: lsar_pkg::INTEG_RST,
                                  rate: lsar_pkg::RATE_RST};
            end
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= lsar_pkg::mode_t'(cfg_wr_data);
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg                <= 1'b1;
                count_reg[current_is_uv_reg] <= raw_reg;
                current_is_uv_reg            <= next_is_uv;
                chan_reg[next_is_uv]         <= range_res.set;
                if (changed) begin
                    applied_is_uv_reg <= next_is_uv;
                    applied_reg       <= range_res.set;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            raw_reg <= s_raw_count;
        end
        if (advance) begin
            measured_reg <= current_is_uv_reg;
            echo_reg     <= raw_reg;
            next_uv_reg  <= next_is_uv;
            needed_reg   <= range_res.needed;
            set_reg      <= range_res.set;
            changed_reg  <= changed;
            wait_reg     <= lsar_pkg::rate_period_ms(range_res.set.rate);
        end
    end

    assign m_valid                 = out_valid_reg;
    assign m_measured_is_uv        = measured_reg;
    assign m_count_echo            = echo_reg;
    assign m_next_is_uv            = next_uv_reg;
    assign m_rescale_needed        = needed_reg;
    assign m_next_gain_code        = set_reg.gain;
    assign m_next_integration_code = set_reg.integ;
    assign m_next_rate_code        = set_reg.rate;
    assign m_settings_changed      = changed_reg;
    assign m_wait_ms               = wait_reg;

endmodule

>>> hw/rtl/lsar_checker.sv
// Port-level checker of the light sensor auto-range block, with its bind.
module lsar_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [lsar_pkg::COUNT_W-1:0]    s_raw_count,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_measured_is_uv,
    input logic [lsar_pkg::COUNT_W-1:0]    m_count_echo,
    input logic                            m_next_is_uv,
    input logic                            m_rescale_needed,
    input logic [lsar_pkg::CODE_W-1:0]     m_next_gain_code,
    input logic [lsar_pkg::CODE_W-1:0]     m_next_integration_code,
    input logic [lsar_pkg::CODE_W-1:0]     m_next_rate_code,
    input logic                            m_settings_changed,
    input logic [lsar_pkg::WAIT_W-1:0]     m_wait_ms
);

    // Stalled input transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_raw_count))
        else $error("input changed while stalled");

    // Stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count_echo) &&
            $stable(m_measured_is_uv) && $stable(m_next_is_uv) &&
            $stable(m_rescale_needed) && $stable(m_next_gain_code) &&
            $stable(m_next_integration_code) && $stable(m_next_rate_code) &&
            $stable(m_settings_changed) && $stable(m_wait_ms))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_codes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_next_gain_code <= lsar_pkg::GAIN_MAX &&
                    m_next_integration_code <= lsar_pkg::INTEG_MAX)
        else $error("gain or integration code out of range");

    a_rate_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_next_rate_code >= lsar_pkg::min_rate_code(m_next_integration_code) &&
                    m_wait_ms == lsar_pkg::rate_period_ms(m_next_rate_code))
        else $error("rate does not cover integration time");

endmodule

bind light_sensor_auto_range_top lsar_checker u_lsar_checker (.*);

>>> tb/tb_light_sensor_auto_range_top.sv
// Self-checking testbench of the light sensor auto-range controller.
module tb_light_sensor_auto_range_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Full scale of the long integration codes follows the count width of the block
    localparam int FS_BITS        = lsar_pkg::COUNT_BITS_DEF;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 225;
    localparam int STALL_LIMIT    = 1000;
    localparam int SETTLE_CYCLES  = 4;

    // One result transaction as the block should present it
    typedef struct {
        logic                         measured_is_uv;
        logic [lsar_pkg::COUNT_W-1:0] count_echo;
        logic                         next_is_uv;
        logic                         rescale_needed;
        lsar_pkg::chan_set_t          next_set;
        logic                         settings_changed;
        logic [lsar_pkg::WAIT_W-1:0]  wait_ms;
    } range_report_t;

    // Clock and reset; every input starts at a known value
    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [lsar_pkg::MODE_W-1:0]  cfg_wr_data = '0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic [lsar_pkg::COUNT_W-1:0] s_raw_count = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic                         m_measured_is_uv;
    logic [lsar_pkg::COUNT_W-1:0] m_count_echo;
    logic                         m_next_is_uv;
    logic                         m_rescale_needed;
    logic [lsar_pkg::CODE_W-1:0]  m_next_gain_code;
    logic [lsar_pkg::CODE_W-1:0]  m_next_integration_code;
    logic [lsar_pkg::CODE_W-1:0]  m_next_rate_code;
    logic                         m_settings_changed;
    logic [lsar_pkg::WAIT_W-1:0]  m_wait_ms;

    always #6 aclk = ~aclk;

    light_sensor_auto_range_top u_dut (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cfg_wr_en               (cfg_wr_en),
        .cfg_wr_data             (cfg_wr_data),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_raw_count             (s_raw_count),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_measured_is_uv        (m_measured_is_uv),
        .m_count_echo            (m_count_echo),
        .m_next_is_uv            (m_next_is_uv),
        .m_rescale_needed        (m_rescale_needed),
        .m_next_gain_code        (m_next_gain_code),
        .m_next_integration_code (m_next_integration_code),
        .m_next_rate_code        (m_next_rate_code),
        .m_settings_changed      (m_settings_changed),
        .m_wait_ms               (m_wait_ms)
    );

    // Counts waiting to be offered, and settings waiting to come out
    logic [lsar_pkg::COUNT_W-1:0] raw_counts_q[$];
    range_report_t                range_due_q[$];

    int counts_queued  = 0;
    int counts_taken   = 0;
    int reports_seen   = 0;
    int rescales_seen  = 0;
    int changes_seen   = 0;
    int modes_written  = 0;
    int mismatches     = 0;

    // Shadow of the block: mode register, channel in hand, per-channel ranging
    // state and the set last applied to the sensor
    lsar_pkg::mode_t              mode_now = lsar_pkg::MODE_ALTERNATE;
    logic                         chan_uv;
    logic [lsar_pkg::COUNT_W-1:0] chan_count [2];
    lsar_pkg::chan_set_t          chan_set   [2];
    logic                         applied_uv;
    lsar_pkg::chan_set_t          applied_set;

    function automatic int unsigned period_of_rate(input logic [lsar_pkg::CODE_W-1:0] code);
        case (code)
            3'd0:    return 25;
            3'd1:    return 50;
            3'd2:    return 100;
            3'd3:    return 200;
            3'd4:    return 500;
            3'd5:    return 1000;
            default: return 2000;
        endcase
    endfunction

    function automatic int unsigned integ_time_of(input logic [lsar_pkg::CODE_W-1:0] code);
        case (code)
            3'd0:    return 400;
            3'd1:    return 200;
            3'd2:    return 100;
            3'd3:    return 50;
            3'd4:    return 25;
            default: return 13;
        endcase
    endfunction

    // Store the count, pick the next channel and range it; queue what must come out
    task automatic auto_range_step(input logic [lsar_pkg::COUNT_W-1:0] raw);
        range_report_t       rep;
        logic                measured;
        logic                nxt;
        lsar_pkg::chan_set_t st;
        logic [63:0]         x;
        logic [63:0]         fs;
        logic                needed;
        logic                changed;

        measured             = chan_uv;
        chan_count[measured] = raw;
        case (mode_now)
            lsar_pkg::MODE_AMBIENT:   nxt = 1'b0;
            lsar_pkg::MODE_UV:        nxt = 1'b1;
            lsar_pkg::MODE_ALTERNATE: nxt = ~measured;
            default:                  nxt = measured;
        endcase
        chan_uv = nxt;

        st     = chan_set[nxt];
        x      = 64'(chan_count[nxt]) * 64'd10;
        // The shortest integration has a fixed, much smaller full scale
        fs     = 64'd1 << ((st.integ >= lsar_pkg::INTEG_MAX) ? lsar_pkg::FS_BITS_SHORT :
                           FS_BITS - int'(st.integ));
        needed = 1'b0;
        // A crossing flags a rescale even when the code is already pinned
        if (x < 2 * fs) begin
            if (st.gain < lsar_pkg::GAIN_MAX) st.gain = st.gain + 1'b1;
            needed = 1'b1;
        end
        if (x < fs) begin
            if (st.integ != '0) st.integ = st.integ - 1'b1;
            needed = 1'b1;
        end
        if (x > 8 * fs) begin
            if (st.gain != '0) st.gain = st.gain - 1'b1;
            needed = 1'b1;
        end
        if (x > 9 * fs) begin
            if (st.integ < lsar_pkg::INTEG_MAX) st.integ = st.integ + 1'b1;
            needed = 1'b1;
        end
        // Slow the rate until its period covers the integration; never speed it up
        while (integ_time_of(st.integ) > period_of_rate(st.rate) &&
               st.rate < lsar_pkg::RATE_SAT)
            st.rate = st.rate + 1'b1;
        chan_set[nxt] = st;

        changed = (nxt != applied_uv) || (st != applied_set);
        if (changed) begin
            applied_uv  = nxt;
            applied_set = st;
        end

        rep.measured_is_uv   = measured;
        rep.count_echo       = raw;
        rep.next_is_uv       = nxt;
        rep.rescale_needed   = needed;
        rep.next_set         = st;
        rep.settings_changed = changed;
        rep.wait_ms          = lsar_pkg::WAIT_W'(period_of_rate(st.rate));
        range_due_q.push_back(rep);
    endtask

    // Random count: half close to one of the four thresholds of some integration
    // code, the rest spread over the whole range, over low counts or at its ends
    function automatic logic [lsar_pkg::COUNT_W-1:0] pick_raw_count();
        int unsigned code;
        int unsigned bits;
        int unsigned mult;
        longint      val;

        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                code = $urandom_range(0, 5);
                bits = (code == 5) ? lsar_pkg::FS_BITS_SHORT : FS_BITS - code;
                case ($urandom_range(0, 3))
                    0:       mult = 1;
                    1:       mult = 2;
                    2:       mult = 8;
                    default: mult = 9;
                endcase
                val = ((longint'(mult) << bits) / 10) + $urandom_range(0, 6) - 3;
                if (val < 0) val = 0;
                if (val > (1 << lsar_pkg::COUNT_W) - 1) val = (1 << lsar_pkg::COUNT_W) - 1;
                return lsar_pkg::COUNT_W'(val);
            end
            5, 6:    return lsar_pkg::COUNT_W'($urandom);
            7, 8:    return lsar_pkg::COUNT_W'($urandom_range(0, 16383));
            default: return ($urandom_range(0, 1) == 0) ? '0 : '1;
        endcase
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Source side: offer queued counts, hold each until taken, at times idle between
    int   src_wait = 0;
    logic src_calm = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                auto_range_step(s_raw_count);
                counts_taken++;
            end
            // A pending transaction not yet taken is held as it stands
            if (!s_valid || s_ready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_valid <= 1'b0;
                end else if (raw_counts_q.size() != 0) begin
                    s_valid     <= 1'b1;
                    s_raw_count <= raw_counts_q.pop_front();
                    // Switch now and then between gap-free stretches and random gaps
                    if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
                    src_wait = src_calm ? 0 : $urandom_range(0, 11);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: compare each transaction with the oldest expectation, stall at random
    int   snk_wait = 0;
    logic snk_calm = 1'b0;

    always @(posedge aclk) begin
        range_report_t want;

        if (!aresetn) begin
            m_ready  <= 1'b0;
            snk_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (range_due_q.size() == 0) begin
                    $error("result with no expectation waiting: count_echo %0d", m_count_echo);
                    mismatches++;
                end else begin
                    want = range_due_q.pop_front();
                    reports_seen++;
                    if (want.rescale_needed) rescales_seen++;
                    if (want.settings_changed) changes_seen++;
                    check_field("measured_is_uv", want.measured_is_uv, m_measured_is_uv);
                    check_field("count_echo", want.count_echo, m_count_echo);
                    check_field("next_is_uv", want.next_is_uv, m_next_is_uv);
                    check_field("rescale_needed", want.rescale_needed, m_rescale_needed);
                    check_field("next_gain_code", want.next_set.gain, m_next_gain_code);
                    check_field("next_integration_code", want.next_set.integ,
                                m_next_integration_code);
                    check_field("next_rate_code", want.next_set.rate, m_next_rate_code);
                    check_field("settings_changed", want.settings_changed,
                                m_settings_changed);
                    check_field("wait_ms", want.wait_ms, m_wait_ms);
                end
                if ($urandom_range(0, 63) == 0) snk_calm = !snk_calm;
                snk_wait = snk_calm ? 0 : $urandom_range(0, 11);
            end
            if (snk_wait > 0) begin
                snk_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with work outstanding but no transaction on either side
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (counts_taken == counts_queued && range_due_q.size() == 0 && !s_valid)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: %0d cycles without a transaction, %0d results outstanding",
                         stall_cycles, range_due_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Wait until every count is taken and every result checked, then let the pipe settle
    task automatic drain_block();
        while (counts_taken != counts_queued || range_due_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the mode register while the block is idle; the shadow follows at once
    task automatic write_mode(input lsar_pkg::mode_t mode);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_now  = mode;
        modes_written++;
    endtask

    task automatic queue_count(input logic [lsar_pkg::COUNT_W-1:0] raw);
        raw_counts_q.push_back(raw);
        counts_queued++;
    endtask

    initial begin
        logic [lsar_pkg::COUNT_W-1:0] directed [$];
        lsar_pkg::mode_t              mode;

        // Reset state of the shadow matches the block after reset
        chan_uv     = 1'b0;
        applied_uv  = 1'b0;
        applied_set = '{gain: lsar_pkg::GAIN_RST, integ: lsar_pkg::INTEG_RST,
                        rate: lsar_pkg::RATE_RST};
        for (int c = 0; c < 2; c++) begin
            chan_count[c] = '0;
            chan_set[c]   = '{gain: lsar_pkg::GAIN_RST, integ: lsar_pkg::INTEG_RST,
                              rate: lsar_pkg::RATE_RST};
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part in the reset mode (alternate): zeros pin gain at its top and
        // integration at its longest, full counts walk them back toward the short end,
        // then counts either side of the longest and shortest integration thresholds
        directed = '{20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
                     20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                     20'd209715, 20'd209716, 20'd104857, 20'd104858,
                     20'd838860, 20'd838861, 20'd943718, 20'd943719,
                     20'd819, 20'd820, 20'd7372, 20'd7373, 20'd1};
        foreach (directed[i]) queue_count(directed[i]);
        drain_block();

        // Random phases: every mode once, the two ends first, then modes at random
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       mode = lsar_pkg::MODE_HOLD;
                1:       mode = lsar_pkg::MODE_AMBIENT;
                2:       mode = lsar_pkg::MODE_UV;
                3:       mode = lsar_pkg::MODE_ALTERNATE;
                default: mode = lsar_pkg::mode_t'($urandom_range(0, 3));
            endcase
            write_mode(mode);
            for (int i = 0; i < PHASE_ITEMS; i++) queue_count(pick_raw_count());
            drain_block();
        end

        $display("Checked %0d range results from %0d counts across %0d mode writes.",
                 reports_seen, counts_taken, modes_written);
        $display("Rescale flagged on %0d results, applied settings changed on %0d.",
                 rescales_seen, changes_seen);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
